@@ rtl/nstp_pkg.sv @@
// ----------------------------------------------------------------------------
// nstp_pkg
// Types, constants and helper functions for the nearest-neighbour scaler.
// ----------------------------------------------------------------------------
package nstp_pkg;

    localparam int MAX_SIDE     = 256;
    localparam int MAX_SCALE_Q8 = 4096;
    localparam int MIN_SCALE_Q8 = 26;

    localparam int SIDE_W  = 9;
    localparam int SCALE_W = 13;
    localparam int COORD_W = 12;
    localparam int FRAC_W  = 8;
    localparam int NUM_W   = COORD_W + FRAC_W;
    localparam int INDEX_W = 16;
    localparam int PIXEL_W = 32;
    localparam int OSIZE_W = SIDE_W + SCALE_W - FRAC_W;
    localparam int DEPTH   = 65536;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_SCALE      = 2'd2,
        REG_TINT       = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] pixel_index;
        logic [PIXEL_W-1:0] pixel_value;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_W-1:0] out_pixel;
        logic               out_of_range;
    } t_out_item;

    // one lane of the restoring divider
    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [SCALE_W-1:0] rem;
        logic [NUM_W-1:0]   quo;
    } t_div_lane;

    typedef struct packed {
        logic               v;
        logic               mode;
        logic               oor;
        logic [INDEX_W-1:0] idx;
        logic [PIXEL_W-1:0] val;
        t_div_lane          lx;
        t_div_lane          ly;
    } t_stage;

    typedef struct packed {
        logic               v;
        logic               mode;
        logic               oor;
        logic [INDEX_W-1:0] addr;
        logic [PIXEL_W-1:0] val;
    } t_mem_op;

    // one quotient bit; remainder stays below the divisor
    function automatic t_div_lane div_step(input t_div_lane l, input logic [SCALE_W-1:0] s);
        t_div_lane        o;
        logic [SCALE_W:0] t;
        logic             ge;
        t     = {l.rem, l.num[NUM_W-1]};
        ge    = (t >= {1'b0, s});
        o.rem = ge ? SCALE_W'(t - {1'b0, s}) : t[SCALE_W-1:0];
        o.num = {l.num[NUM_W-2:0], 1'b0};
        o.quo = {l.quo[NUM_W-2:0], ge};
        return o;
    endfunction

    function automatic logic [PIXEL_W-1:0] tint_pixel(input logic [PIXEL_W-1:0] p,
                                                      input logic [PIXEL_W-1:0] t);
        logic [8:0] r;
        logic [8:0] g;
        logic [8:0] b;
        r = {1'b0, t[23:16]} + {1'b0, p[23:16]};
        g = {1'b0, t[15:8]}  + {1'b0, p[15:8]};
        b = {1'b0, t[7:0]}   + {1'b0, p[7:0]};
        if (p == '0) begin
            return '0;
        end
        return {t[31:24], r[8:1], g[8:1], b[8:1]};
    endfunction

endpackage

@@ rtl/nearest_scale_tint_pixel.sv @@
// ----------------------------------------------------------------------------
// nearest_scale_tint_pixel
// Throughput: one item per cycle unless the output stalls, set by the
// 20-stage pipelined divider and the single RAM port, which a write or a
// read uses once per item. A write lands in the image store from the
// address register, after the input register and the divider stages.
// Reset: clears pipeline valids and loads register defaults; the image store
// is not cleared.
// ----------------------------------------------------------------------------
module nearest_scale_tint_pixel
    import nstp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SIDE_W-1:0]  r_src_width;
    logic [SIDE_W-1:0]  r_src_height;
    logic [SCALE_W-1:0] r_scale;
    logic [PIXEL_W-1:0] r_tint;

    logic [SIDE_W-1:0]  n_w;
    logic [SIDE_W-1:0]  n_h;
    logic [SCALE_W-1:0] n_s;
    logic [SIDE_W-1:0]  r_w;
    logic [SCALE_W-1:0] r_s;
    logic [OSIZE_W-1:0] r_ow;
    logic [OSIZE_W-1:0] r_oh;

    t_stage  r_d [0:NUM_W];
    t_stage  n_d [0:NUM_W];
    t_mem_op r_m;
    t_mem_op n_m;
    logic [INDEX_W+SIDE_W-1:0] row_prod;

    logic      r_t_v;
    logic      r_t_oor;
    logic      r_o_v;
    t_out_item r_o;

    logic               adv;
    logic               rdy_o;
    logic               ram_we;
    logic               ram_re;
    logic [PIXEL_W-1:0] ram_rdata;
    t_reg_idx           reg_sel;
    logic               cfg_wr;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SIDE_W'(256);
            r_src_height <= SIDE_W'(256);
            r_scale      <= SCALE_W'(256);
            r_tint       <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_SRC_WIDTH:  r_src_width  <= pwdata[SIDE_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= pwdata[SIDE_W-1:0];
                REG_SCALE:      r_scale      <= pwdata[SCALE_W-1:0];
                REG_TINT:       r_tint       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SRC_WIDTH:  prdata = {{(32-SIDE_W){1'b0}}, r_src_width};
            REG_SRC_HEIGHT: prdata = {{(32-SIDE_W){1'b0}}, r_src_height};
            REG_SCALE:      prdata = {{(32-SCALE_W){1'b0}}, r_scale};
            REG_TINT:       prdata = r_tint;
            default:        prdata = '0;
        endcase
    end

    // effective sizes and scale, registered once per cycle
    always_comb begin
        n_w = (r_src_width > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : r_src_width;
        n_h = (r_src_height > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : r_src_height;
        if (r_scale < MIN_SCALE_Q8) begin
            n_s = SCALE_W'(MIN_SCALE_Q8);
        end else if (r_scale > MAX_SCALE_Q8) begin
            n_s = SCALE_W'(MAX_SCALE_Q8);
        end else begin
            n_s = r_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= SIDE_W'(256);
            r_s  <= SCALE_W'(256);
            r_ow <= OSIZE_W'(256);
            r_oh <= OSIZE_W'(256);
        end else begin
            r_w  <= n_w;
            r_s  <= n_s;
            r_ow <= OSIZE_W'(({{SCALE_W{1'b0}}, n_w} * {{SIDE_W{1'b0}}, n_s}) >> FRAC_W);
            r_oh <= OSIZE_W'(({{SCALE_W{1'b0}}, n_h} * {{SIDE_W{1'b0}}, n_s}) >> FRAC_W);
        end
    end

    // ---------------- pipeline control ----------------
    assign rdy_o      = !r_o_v || i_out_ready;
    assign adv        = !r_t_v || rdy_o;
    assign o_in_ready = adv;

    // ---------------- divider pipeline ----------------
    always_comb begin
        n_d[0].v       = i_in_valid;
        n_d[0].mode    = i_in_data.mode;
        n_d[0].oor     = 1'b0;
        n_d[0].idx     = i_in_data.pixel_index;
        n_d[0].val     = i_in_data.pixel_value;
        n_d[0].lx.num  = {i_in_data.out_x, {FRAC_W{1'b0}}};
        n_d[0].lx.rem  = '0;
        n_d[0].lx.quo  = '0;
        n_d[0].ly.num  = {i_in_data.out_y, {FRAC_W{1'b0}}};
        n_d[0].ly.rem  = '0;
        n_d[0].ly.quo  = '0;
        for (int k = 1; k <= NUM_W; k++) begin
            n_d[k]    = r_d[k-1];
            n_d[k].lx = div_step(r_d[k-1].lx, r_s);
            n_d[k].ly = div_step(r_d[k-1].ly, r_s);
        end
        // range check on the raw coordinates before the first shift
        n_d[1].oor = (OSIZE_W'(r_d[0].lx.num[NUM_W-1:FRAC_W]) >= r_ow) ||
                     (OSIZE_W'(r_d[0].ly.num[NUM_W-1:FRAC_W]) >= r_oh);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= NUM_W; k++) begin
            if (!i_rst_n) begin
                r_d[k].v <= 1'b0;
            end else if (adv) begin
                r_d[k] <= n_d[k];
            end
        end
    end

    // ---------------- address stage ----------------
    assign row_prod = {{SIDE_W{1'b0}}, r_d[NUM_W].ly.quo[INDEX_W-1:0]} *
                      {{INDEX_W{1'b0}}, r_w};

    always_comb begin
        n_m.v    = r_d[NUM_W].v;
        n_m.mode = r_d[NUM_W].mode;
        n_m.oor  = r_d[NUM_W].oor;
        n_m.val  = r_d[NUM_W].val;
        if (r_d[NUM_W].mode == MODE_READ) begin
            n_m.addr = row_prod[INDEX_W-1:0] + r_d[NUM_W].lx.quo[INDEX_W-1:0];
        end else begin
            n_m.addr = r_d[NUM_W].idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m.v <= 1'b0;
        end else if (adv) begin
            r_m <= n_m;
        end
    end

    // ---------------- image store ----------------
    assign ram_we = adv && r_m.v && (r_m.mode == MODE_WRITE);
    assign ram_re = adv && r_m.v && (r_m.mode == MODE_READ);

    nstp_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (r_m.addr),
        .i_wdata (r_m.val),
        .o_rdata (ram_rdata)
    );

    // read data stage: writes leave the pipeline at the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (adv) begin
            r_t_v <= r_m.v && (r_m.mode == MODE_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t_oor <= r_m.oor;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (rdy_o) begin
            r_o_v <= r_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            if (r_t_oor) begin
                r_o.out_pixel    <= '0;
                r_o.out_of_range <= 1'b1;
            end else begin
                r_o.out_pixel    <= tint_pixel(ram_rdata, r_tint);
                r_o.out_of_range <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_data  = r_o;

    // ---------------- assertions ----------------
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store read and written in one cycle");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_t_v && r_o_v))
        else $error("input stalled with a free slot downstream");

    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t_v && !rdy_o) |=> $stable(ram_rdata))
        else $error("read data lost while output stalled");

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> r_t_v)
        else $error("store read without a pending result");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_of_range) |-> (o_out_data.out_pixel == '0))
        else $error("out-of-range result carries a pixel");

endmodule

@@ rtl/nstp_ram.sv @@
// ----------------------------------------------------------------------------
// nstp_ram
// Generic single-port synchronous RAM, registered read held while idle.
// ----------------------------------------------------------------------------
module nstp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/tb_nearest_scale_tint_pixel.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_scale_tint_pixel
// Drives pixel loads and scaled-pixel requests into the nearest-neighbour
// scaler, keeps a shadow copy of the image store and the registers, and
// checks every returned pixel and range flag in order. Register settings are
// swept between traffic phases, including the clamped scale and size cases.
// ----------------------------------------------------------------------------
module tb_nearest_scale_tint_pixel
    import nstp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 30;   // covers the whole pipeline

    typedef enum int {PACE_STEADY, PACE_BURSTY} t_pace;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    t_in_item      in_data   = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    t_out_item     out_data;
    logic          psel      = 1'b0;
    logic          penable   = 1'b0;
    logic          pwrite    = 1'b0;
    logic [3:0]    paddr     = '0;
    logic [31:0]   pwdata    = '0;
    logic [31:0]   prdata;
    logic          pready;

    // shadow of the block's registers and image store
    logic [SIDE_W-1:0]  cfg_width  = 9'(MAX_SIDE);
    logic [SIDE_W-1:0]  cfg_height = 9'(MAX_SIDE);
    logic [SCALE_W-1:0] cfg_scale  = 13'd256;
    logic [PIXEL_W-1:0] cfg_tint   = '0;
    logic [PIXEL_W-1:0] image_copy [DEPTH];
    bit                 pixel_loaded [DEPTH];

    t_out_item pending_pixels [$];
    t_out_item want;
    int        mismatch_count = 0;
    int        hold_request   = 0;
    t_pace     tx_pace        = PACE_BURSTY;
    t_pace     rx_pace        = PACE_BURSTY;

    nearest_scale_tint_pixel DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAIL nearest_scale_tint_pixel");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------
    function automatic int unsigned eff_scale();
        if (cfg_scale < MIN_SCALE_Q8) return MIN_SCALE_Q8;
        if (cfg_scale > MAX_SCALE_Q8) return MAX_SCALE_Q8;
        return cfg_scale;
    endfunction

    function automatic int unsigned clamp_side(input logic [SIDE_W-1:0] side);
        return (side > MAX_SIDE) ? MAX_SIDE : side;
    endfunction

    function automatic int unsigned out_extent(input logic [SIDE_W-1:0] side);
        return (clamp_side(side) * eff_scale()) >> 8;
    endfunction

    // source raster address of an output pixel; 0 when the request is outside
    function automatic bit locate_source(input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y,
                                         output logic [INDEX_W-1:0] addr);
        int unsigned s;
        int unsigned xi;
        int unsigned yi;
        s    = eff_scale();
        xi   = x;
        yi   = y;
        addr = '0;
        if (xi >= out_extent(cfg_width) || yi >= out_extent(cfg_height)) return 1'b0;
        addr = 16'(((yi << 8) / s) * clamp_side(cfg_width) + (xi << 8) / s);
        return 1'b1;
    endfunction

    function automatic logic [7:0] mean_byte(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

    function automatic t_out_item predicted_pixel(input t_in_item it);
        t_out_item          r;
        logic [INDEX_W-1:0] addr;
        logic [PIXEL_W-1:0] p;
        r = '0;
        if (!locate_source(it.out_x, it.out_y, addr)) begin
            r.out_of_range = 1'b1;
            return r;
        end
        p = image_copy[addr];
        // a fully zero pixel is passed through untinted
        if (p != '0) begin
            r.out_pixel = {cfg_tint[31:24], mean_byte(cfg_tint[23:16], p[23:16]),
                           mean_byte(cfg_tint[15:8], p[15:8]),
                           mean_byte(cfg_tint[7:0], p[7:0])};
        end
        return r;
    endfunction

    function automatic logic [31:0] reg_value(input t_reg_idx idx);
        case (idx)
            REG_SRC_WIDTH:  return 32'(cfg_width);
            REG_SRC_HEIGHT: return 32'(cfg_height);
            REG_SCALE:      return 32'(cfg_scale);
            default:        return cfg_tint;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap(input t_pace pace);
        int r;
        if (pace == PACE_STEADY) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned extent);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0 || extent == 0) return 12'($urandom);
        if (r == 1 && extent <= 4095) return 12'(extent);
        if (r == 2) return 12'(extent - 1);
        return 12'($urandom_range(0, extent - 1));
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // the unused fields of either item kind carry noise
    function automatic t_in_item load_item(input logic [INDEX_W-1:0] idx,
                                           input logic [PIXEL_W-1:0] val);
        t_in_item it;
        it.mode        = MODE_WRITE;
        it.pixel_index = idx;
        it.pixel_value = val;
        it.out_x       = 12'($urandom);
        it.out_y       = 12'($urandom);
        return it;
    endfunction

    function automatic t_in_item fetch_item(input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
        t_in_item it;
        it.mode        = MODE_READ;
        it.pixel_index = 16'($urandom);
        it.pixel_value = $urandom;
        it.out_x       = x;
        it.out_y       = y;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap(tx_pace);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (it.mode == MODE_WRITE) begin
            image_copy[it.pixel_index]   = it.pixel_value;
            pixel_loaded[it.pixel_index] = 1'b1;
        end else begin
            pending_pixels.push_back(predicted_pixel(it));
        end
    endtask

    // loads the source pixel first if the store has never held it
    task automatic request_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        logic [INDEX_W-1:0] addr;
        if (locate_source(x, y, addr) && !pixel_loaded[addr])
            send_item(load_item(addr, random_pixel()));
        send_item(fetch_item(x, y));
    endtask

    task automatic random_traffic(input int count);
        logic [INDEX_W-1:0] addr;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 7))
                0: send_item(load_item(16'($urandom), random_pixel()));
                1: begin
                    // overwrite a pixel currently in view
                    if (locate_source(pick_coord(out_extent(cfg_width)),
                                      pick_coord(out_extent(cfg_height)), addr))
                        send_item(load_item(addr, random_pixel()));
                end
                default: request_pixel(pick_coord(out_extent(cfg_width)),
                                       pick_coord(out_extent(cfg_height)));
            endcase
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_pixels.size() != 0);
        // loads leave no result, so let the pipeline empty as well
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_read(input t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== reg_value(idx)) begin
            $display("%0t ns: register %s read back: expected %h, actual %h",
                     $time, idx.name(), reg_value(idx), prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_SRC_WIDTH:  cfg_width  = val[SIDE_W-1:0];
            REG_SRC_HEIGHT: cfg_height = val[SIDE_W-1:0];
            REG_SCALE:      cfg_scale  = val[SCALE_W-1:0];
            REG_TINT:       cfg_tint   = val;
            default: ;
        endcase
        reg_read(idx);
    endtask

    task automatic set_config(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                              input logic [SCALE_W-1:0] s, input logic [PIXEL_W-1:0] tint);
        settle();
        reg_write(REG_SRC_WIDTH, 32'(w));
        reg_write(REG_SRC_HEIGHT, 32'(h));
        reg_write(REG_SCALE, 32'(s));
        reg_write(REG_TINT, tint);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_defaults();
        reg_read(REG_SRC_WIDTH);
        reg_read(REG_SRC_HEIGHT);
        reg_read(REG_SCALE);
        reg_read(REG_TINT);
    endtask

    task automatic test_directed_extremes();
        tx_pace = PACE_STEADY;
        send_item(load_item(16'h0000, 32'h0000_0000));
        send_item(load_item(16'h0001, 32'hFFFF_FFFF));
        send_item(load_item(16'hFFFF, 32'h1234_5678));
        send_item(load_item(16'h00FF, 32'h80FF_0001));
        send_item(load_item(16'hFF00, 32'h0000_0001));
        request_pixel(12'd0, 12'd0);       // zero pixel passes through
        request_pixel(12'd1, 12'd0);
        request_pixel(12'd255, 12'd255);   // last store entry
        request_pixel(12'd255, 12'd0);
        request_pixel(12'd0, 12'd255);
        request_pixel(12'd256, 12'd0);     // just outside, each axis
        request_pixel(12'd0, 12'd256);
        request_pixel(12'hFFF, 12'hFFF);
        request_pixel(12'hFFF, 12'd0);
        send_item(load_item(16'hFFFF, 32'hFFFF_FFFF));
        request_pixel(12'd255, 12'd255);
        set_config(9'(MAX_SIDE), 9'(MAX_SIDE), 13'd256, 32'hFFFF_FFFF);
        request_pixel(12'd1, 12'd0);
        request_pixel(12'd0, 12'd0);
        request_pixel(12'd255, 12'd0);
        request_pixel(12'd255, 12'd255);
        tx_pace = PACE_BURSTY;
    endtask

    task automatic test_scale_range();
        logic [SCALE_W-1:0] scales [13];
        scales = '{13'd0, 13'd25, 13'd26, 13'd27, 13'd128, 13'd255, 13'd256,
                   13'd257, 13'd1000, 13'd4095, 13'd4096, 13'd4097, 13'h1FFF};
        foreach (scales[i]) begin
            set_config(9'(MAX_SIDE), 9'(MAX_SIDE), scales[i], $urandom);
            random_traffic(12);
        end
    endtask

    task automatic test_source_size();
        logic [SIDE_W-1:0] widths  [9];
        logic [SIDE_W-1:0] heights [9];
        widths  = '{9'd0, 9'd256, 9'd0, 9'd1, 9'd1, 9'd256, 9'h1FF, 9'd300, 9'd257};
        heights = '{9'd256, 9'd0, 9'd0, 9'd1, 9'd256, 9'd1, 9'h1FF, 9'd257, 9'd40};
        foreach (widths[i]) begin
            set_config(widths[i], heights[i], 13'($urandom_range(26, 1024)), $urandom);
            random_traffic(10);
        end
    endtask

    task automatic test_tint_colours();
        logic [PIXEL_W-1:0] tints [5];
        tints = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000, $urandom};
        foreach (tints[i]) begin
            set_config(9'd64, 9'd64, 13'd512, tints[i]);
            random_traffic(10);
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_output_stall();
        set_config(9'd128, 9'd96, 13'd300, $urandom);
        tx_pace      = PACE_STEADY;
        hold_request = 300;
        for (int i = 0; i < 100; i++)
            request_pixel(pick_coord(out_extent(cfg_width)), pick_coord(out_extent(cfg_height)));
        tx_pace = PACE_BURSTY;
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            random_traffic(20);
            in_valid <= 1'b0;
            do @(posedge clk); while (pending_pixels.size() != 0);
        end
    endtask

    task automatic test_random_mix();
        logic [SIDE_W-1:0]  w;
        logic [SIDE_W-1:0]  h;
        logic [SCALE_W-1:0] s;
        for (int phase = 0; phase < 6; phase++) begin
            w = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(1, MAX_SIDE));
            h = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(1, MAX_SIDE));
            s = ($urandom_range(0, 7) == 0) ? 13'($urandom)
                                            : 13'($urandom_range(MIN_SCALE_Q8, MAX_SCALE_Q8));
            set_config(w, h, s, $urandom);
            tx_pace = (phase % 3 == 2) ? PACE_STEADY : PACE_BURSTY;
            rx_pace = (phase % 2 == 1) ? PACE_STEADY : PACE_BURSTY;
            random_traffic(20);
        end
        tx_pace = PACE_BURSTY;
        rx_pace = PACE_BURSTY;
    endtask

    // ------------------------------------------------------------------------
    // Receiver and result check
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
                stall = pick_gap(rx_pace);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t ns: unexpected transfer: expected none, actual pixel %h flag %b",
                         $time, out_data.out_pixel, out_data.out_of_range);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (out_data.out_pixel !== want.out_pixel) begin
                    $display("%0t ns: out_pixel: expected %h, actual %h",
                             $time, want.out_pixel, out_data.out_pixel);
                    mismatch_count++;
                end
                if (out_data.out_of_range !== want.out_of_range) begin
                    $display("%0t ns: out_of_range: expected %b, actual %b",
                             $time, want.out_of_range, out_data.out_of_range);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_defaults();
        test_directed_extremes();
        test_scale_range();
        test_source_size();
        test_tint_colours();
        test_output_stall();
        test_sender_pause();
        test_random_mix();
        settle();
        if (mismatch_count == 0) begin
            $display("PASS nearest_scale_tint_pixel");
        end else begin
            $display("FAIL nearest_scale_tint_pixel");
        end
        $finish;
    end

endmodule
